/* sv/rtt_pkg.sv */
package rtt_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT    = 3'd0,
    REQ_FIND_SEQ  = 3'd1,
    REQ_FIND_TIME = 3'd2,
    REQ_DEL_SLOT  = 3'd3,
    REQ_DEL_ALL   = 3'd4,
    REQ_DECREMENT = 3'd5,
    REQ_COUNT     = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE  = 4'b0001,
    FSM_SCAN  = 4'b0010,
    FSM_APPLY = 4'b0100,
    FSM_RESP  = 4'b1000
  } fsm_e;

  localparam int unsigned CountOutW = 5;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] orig_time;
    logic [15:0] rem_time;
    logic [7:0]  retry;
    logic [15:0] seg_len;
    logic [15:0] dest;
    logic [7:0]  handle;
  } entry_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] seq_num;
    logic [15:0] time_value;
    logic [7:0]  retry_count;
    logic [15:0] segment_len;
    logic [15:0] dest_addr;
    logic [7:0]  buffer_handle;
    logic [3:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic scan;
    logic apply;
  } ctl_t;

endpackage

/* sv/rtt_intf.sv */
interface rtt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] seq_num;
  logic [15:0] time_value;
  logic [7:0]  retry_count;
  logic [15:0] segment_len;
  logic [15:0] dest_addr;
  logic [7:0]  buffer_handle;
  logic [3:0]  slot_index;

  modport source (output valid, req_type, seq_num, time_value, retry_count,
                  segment_len, dest_addr, buffer_handle, slot_index,
                  input ready);
  modport sink (input valid, req_type, seq_num, time_value, retry_count,
                segment_len, dest_addr, buffer_handle, slot_index,
                output ready);
endinterface

interface rtt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [3:0]  hit_slot;
  logic [15:0] hit_seq;
  logic [15:0] hit_original_time;
  logic [15:0] hit_remaining_time;
  logic [7:0]  hit_retry;
  logic [15:0] hit_segment_len;
  logic [15:0] hit_dest_addr;
  logic [7:0]  hit_buffer_handle;
  logic [4:0]  entry_count;

  modport source (output valid, status, found, hit_slot, hit_seq, hit_original_time,
                  hit_remaining_time, hit_retry, hit_segment_len, hit_dest_addr,
                  hit_buffer_handle, entry_count, input ready);
  modport sink (input valid, status, found, hit_slot, hit_seq, hit_original_time,
                hit_remaining_time, hit_retry, hit_segment_len, hit_dest_addr,
                hit_buffer_handle, entry_count, output ready);
endinterface

/* sv/rtt_cell.sv */
module rtt_cell #(
  parameter int unsigned IdxW = 4,
  parameter int unsigned Idx  = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtt_pkg::ctl_t       ctl_i,
  input  rtt_pkg::req_t       req_i,
  input  logic                hit_i,
  input  logic [IdxW-1:0]     hit_slot_i,
  input  logic [IdxW-1:0]     hit_rank_i,
  input  logic                cin_vld_i,
  input  logic [IdxW-1:0]     cin_slot_i,
  input  logic [IdxW-1:0]     cin_rank_i,
  input  rtt_pkg::entry_t     cin_entry_i,
  output logic                cout_vld_o,
  output logic [IdxW-1:0]     cout_slot_o,
  output logic [IdxW-1:0]     cout_rank_o,
  output rtt_pkg::entry_t     cout_entry_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic            valid_q;
  rtt_pkg::entry_t entry_q;
  logic [IdxW-1:0] rank_q;

  logic            take;
  logic            older_ok;
  logic            cand_vld_q;
  logic [IdxW-1:0] cand_slot_q, cand_rank_q;
  rtt_pkg::entry_t cand_entry_q;
  logic            me;

  assign older_ok = !cin_vld_i || (rank_q < cin_rank_i);
  assign me       = (hit_slot_i == MyIdx);

  always_comb begin
    case (rtt_pkg::req_e'(req_i.req_type))
      rtt_pkg::REQ_INSERT:    take = !valid_q && !cin_vld_i;
      rtt_pkg::REQ_FIND_SEQ:  take = valid_q && (entry_q.seq == req_i.seq_num) && older_ok;
      rtt_pkg::REQ_FIND_TIME: take = valid_q && (entry_q.rem_time == req_i.time_value) &&
                                     older_ok;
      rtt_pkg::REQ_DEL_SLOT:  take = valid_q && (32'(req_i.slot_index) == Idx);
      default:                take = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.scan) begin
      if (take) begin
        cand_vld_q   <= 1'b1;
        cand_slot_q  <= MyIdx;
        cand_rank_q  <= rank_q;
        cand_entry_q <= entry_q;
      end else begin
        cand_vld_q   <= cin_vld_i;
        cand_slot_q  <= cin_slot_i;
        cand_rank_q  <= cin_rank_i;
        cand_entry_q <= cin_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.apply) begin
      case (rtt_pkg::req_e'(req_i.req_type))
        rtt_pkg::REQ_INSERT:   if (hit_i && me) valid_q <= 1'b1;
        rtt_pkg::REQ_DEL_SLOT: if (hit_i && me) valid_q <= 1'b0;
        rtt_pkg::REQ_DEL_ALL:  valid_q <= 1'b0;
        default:               valid_q <= valid_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.apply) begin
      case (rtt_pkg::req_e'(req_i.req_type))
        rtt_pkg::REQ_INSERT: begin
          if (hit_i && me) begin
            entry_q.seq       <= req_i.seq_num;
            entry_q.orig_time <= req_i.time_value;
            entry_q.rem_time  <= req_i.time_value;
            entry_q.retry     <= req_i.retry_count;
            entry_q.seg_len   <= req_i.segment_len;
            entry_q.dest      <= req_i.dest_addr;
            entry_q.handle    <= req_i.buffer_handle;
            rank_q            <= '0;
          end else if (hit_i && valid_q) begin
            rank_q <= rank_q + 1'b1;
          end
        end
        rtt_pkg::REQ_DEL_SLOT: begin
          if (hit_i && !me && valid_q && (rank_q > hit_rank_i)) rank_q <= rank_q - 1'b1;
        end
        rtt_pkg::REQ_DECREMENT: begin
          if (valid_q) begin
            entry_q.rem_time <= (entry_q.rem_time > req_i.time_value) ?
                                entry_q.rem_time - req_i.time_value : 16'd0;
          end
        end
        default: begin
          rank_q <= rank_q;
        end
      endcase
    end
  end

  assign cout_vld_o   = cand_vld_q;
  assign cout_slot_o  = cand_slot_q;
  assign cout_rank_o  = cand_rank_q;
  assign cout_entry_o = cand_entry_q;

endmodule

/* sv/retransmit_timer_table.sv */
// Retransmission timer table.
// Requests arrive on req (valid/ready); each one yields exactly one
// response on rsp (valid/ready). One request is in flight at a time:
// req.ready is high only while the block is idle.
// Each slot is a cell of a chain. A request is first swept down the
// chain, one cell per cycle, to pick the lowest free slot, the newest
// matching entry or the slot to delete; then all cells update at once.
// The accepted request passes through the scan, apply and response
// states in order; the response is valid in the response state, and
// the next request is taken only after that response transfers.
// Reset clears all slot valid bits and the entry count; slot contents
// are not cleared. When the receiver stalls, the response is held in
// the output register and no new request is taken until it transfers.
module retransmit_timer_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  rtt_req_if.sink   req,
  rtt_rsp_if.source rsp
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  rtt_pkg::fsm_e   state_q, state_d;
  rtt_pkg::req_t   req_q;
  rtt_pkg::ctl_t   ctl;
  logic [IdxW-1:0] cnt_q;
  logic [CntW-1:0] count_q, count_d;

  logic            cv   [TABLE_DEPTH+1];
  logic [IdxW-1:0] cs   [TABLE_DEPTH+1];
  logic [IdxW-1:0] cr   [TABLE_DEPTH+1];
  rtt_pkg::entry_t ce   [TABLE_DEPTH+1];

  logic            hit;
  logic [1:0]      status_d;
  logic            found_d, rep_d;
  rtt_pkg::entry_t rep_entry;

  logic [1:0]      status_q;
  logic            found_q;
  logic [3:0]      slot_q;
  rtt_pkg::entry_t entry_out_q;

  assign cv[0] = 1'b0;
  assign cs[0] = '0;
  assign cr[0] = '0;
  assign ce[0] = '0;

  assign hit = cv[TABLE_DEPTH];

  assign ctl.scan  = (state_q == rtt_pkg::FSM_SCAN);
  assign ctl.apply = (state_q == rtt_pkg::FSM_APPLY);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rtt_cell #(.IdxW(IdxW), .Idx(i)) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .req_i        (req_q),
      .hit_i        (hit),
      .hit_slot_i   (cs[TABLE_DEPTH]),
      .hit_rank_i   (cr[TABLE_DEPTH]),
      .cin_vld_i    (cv[i]),
      .cin_slot_i   (cs[i]),
      .cin_rank_i   (cr[i]),
      .cin_entry_i  (ce[i]),
      .cout_vld_o   (cv[i+1]),
      .cout_slot_o  (cs[i+1]),
      .cout_rank_o  (cr[i+1]),
      .cout_entry_o (ce[i+1])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rtt_pkg::FSM_IDLE:  if (req.valid) state_d = rtt_pkg::FSM_SCAN;
      rtt_pkg::FSM_SCAN:  if (cnt_q == LastIdx) state_d = rtt_pkg::FSM_APPLY;
      rtt_pkg::FSM_APPLY: state_d = rtt_pkg::FSM_RESP;
      rtt_pkg::FSM_RESP:  if (rsp.ready) state_d = rtt_pkg::FSM_IDLE;
      default:            state_d = rtt_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    status_d  = rtt_pkg::ST_OK;
    found_d   = 1'b0;
    rep_d     = 1'b0;
    rep_entry = ce[TABLE_DEPTH];
    count_d   = count_q;
    case (rtt_pkg::req_e'(req_q.req_type))
      rtt_pkg::REQ_INSERT: begin
        if (hit) begin
          rep_d     = 1'b1;
          rep_entry = '{seq: req_q.seq_num, orig_time: req_q.time_value,
                        rem_time: req_q.time_value, retry: req_q.retry_count,
                        seg_len: req_q.segment_len, dest: req_q.dest_addr,
                        handle: req_q.buffer_handle};
          count_d   = count_q + 1'b1;
        end else begin
          status_d = rtt_pkg::ST_FULL;
        end
      end
      rtt_pkg::REQ_FIND_SEQ, rtt_pkg::REQ_FIND_TIME: begin
        if (hit) begin
          rep_d   = 1'b1;
          found_d = 1'b1;
        end else begin
          status_d = rtt_pkg::ST_NOT_FOUND;
        end
      end
      rtt_pkg::REQ_DEL_SLOT: begin
        if (hit) begin
          rep_d   = 1'b1;
          count_d = count_q - 1'b1;
        end else begin
          status_d = rtt_pkg::ST_EMPTY;
        end
      end
      rtt_pkg::REQ_DEL_ALL: count_d = '0;
      default:              count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtt_pkg::FSM_IDLE;
      cnt_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (ctl.scan) cnt_q <= cnt_q + 1'b1;
      else          cnt_q <= '0;
      if (ctl.apply) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      req_q <= '{req_type: req.req_type, seq_num: req.seq_num,
                 time_value: req.time_value, retry_count: req.retry_count,
                 segment_len: req.segment_len, dest_addr: req.dest_addr,
                 buffer_handle: req.buffer_handle, slot_index: req.slot_index};
    end
    if (ctl.apply) begin
      status_q    <= status_d;
      found_q     <= found_d;
      slot_q      <= rep_d ? 4'(cs[TABLE_DEPTH]) : 4'd0;
      entry_out_q <= rep_d ? rep_entry : '0;
    end
  end

  assign req.ready              = (state_q == rtt_pkg::FSM_IDLE);
  assign rsp.valid              = (state_q == rtt_pkg::FSM_RESP);
  assign rsp.status             = status_q;
  assign rsp.found              = found_q;
  assign rsp.hit_slot           = slot_q;
  assign rsp.hit_seq            = entry_out_q.seq;
  assign rsp.hit_original_time  = entry_out_q.orig_time;
  assign rsp.hit_remaining_time = entry_out_q.rem_time;
  assign rsp.hit_retry          = entry_out_q.retry;
  assign rsp.hit_segment_len    = entry_out_q.seg_len;
  assign rsp.hit_dest_addr      = entry_out_q.dest;
  assign rsp.hit_buffer_handle  = entry_out_q.handle;
  assign rsp.entry_count        = rtt_pkg::CountOutW'(count_q);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= TABLE_DEPTH)
    else $error("entry count exceeds table depth");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> (state_q == rtt_pkg::FSM_SCAN))
    else $error("accepted request did not start a sweep");

  a_resp_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready)
    else $error("request taken while a response is pending");

endmodule
